// ===== rtl/core/tsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tsm_pkg
// Types, register map and mapping functions shared by the throttle step mode
// controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tsm_pkg;

  localparam int unsigned CfgAddrW  = 5;
  localparam int unsigned CfgDataW  = 32;
  localparam logic [31:0] DlNever   = '1;

  // Reset values of the configuration registers
  localparam logic        RstBrakeEnable  = 1'b1;
  localparam logic [15:0] RstShortPressMs = 16'd500;
  localparam logic [15:0] RstLongPressMs  = 16'd1000;
  localparam logic [15:0] RstOdHoldMs     = 16'd5000;
  localparam logic [3:0]  RstPressesLow   = 4'd2;
  localparam logic [3:0]  RstPressesMed   = 4'd3;
  localparam logic [6:0]  RstLowPercent   = 7'd30;
  localparam logic [6:0]  RstMedPercent   = 7'd60;

  typedef enum logic [2:0] {
    MODE_BRAKE = 3'd0,
    MODE_NONE  = 3'd1,
    MODE_OFF   = 3'd2,
    MODE_LOW   = 3'd3,
    MODE_MED   = 3'd4,
    MODE_OVER  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    REG_BRAKE_ENABLE   = 3'd0,
    REG_SHORT_PRESS_MS = 3'd1,
    REG_LONG_PRESS_MS  = 3'd2,
    REG_OD_HOLD_MS     = 3'd3,
    REG_PRESSES_LOW    = 3'd4,
    REG_PRESSES_MED    = 3'd5,
    REG_LOW_PERCENT    = 3'd6,
    REG_MED_PERCENT    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic        brake_enable;
    logic [15:0] short_press_ms;
    logic [15:0] long_press_ms;
    logic [15:0] overdrive_hold_ms;
    logic [3:0]  presses_to_low;
    logic [3:0]  presses_to_med;
    logic [6:0]  low_percent;
    logic [6:0]  med_percent;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_press_edge;
    logic        button_release_edge;
    logic        brake_release_edge;
    logic        brake_press_edge;
  } in_item_t;

  typedef struct packed {
    logic [10:0]       pulse_us;
    logic [2:0]        mode_code;
    logic signed [7:0] throttle_percent;
    logic              write_strobe;
  } out_item_t;

  typedef struct packed {
    mode_e       mode_now;
    mode_e       mode_before;
    mode_e       mode_written;
    logic [31:0] short_dl;
    logic [31:0] long_dl;
    logic [31:0] expiry_dl;
    logic        expiry_active;
    logic [3:0]  release_count;
  } st_t;

  localparam st_t StRst = '{
    mode_now:      MODE_OFF,
    mode_before:   MODE_NONE,
    mode_written:  MODE_NONE,
    short_dl:      DlNever,
    long_dl:       DlNever,
    expiry_dl:     DlNever,
    expiry_active: 1'b0,
    release_count: 4'd0
  };

  function automatic mode_e next_mode(mode_e m);
    mode_e r;
    unique case (m)
      MODE_NONE: r = MODE_OFF;
      MODE_OFF:  r = MODE_LOW;
      MODE_LOW:  r = MODE_MED;
      MODE_MED:  r = MODE_OVER;
      default:   r = MODE_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pct_clip(logic [6:0] p);
    return (p > 7'd100) ? 8'd100 : {1'b0, p};
  endfunction

  function automatic logic signed [7:0] pct_of(mode_e m, cfg_t c);
    logic [7:0] r;
    unique case (m)
      MODE_BRAKE: r = 8'h9C;   // -100
      MODE_OFF:   r = 8'd0;
      MODE_LOW:   r = pct_clip(c.low_percent);
      MODE_MED:   r = pct_clip(c.med_percent);
      MODE_OVER:  r = 8'd100;
      default:    r = 8'hFF;   // -1
    endcase
    return $signed(r);
  endfunction

  // 1500+5*pct with brake mapping, else 1000+10*pct; both floored at 990
  function automatic logic [10:0] pulse_of(logic en, logic signed [7:0] pct);
    logic signed [12:0] px;
    logic signed [12:0] r;
    px = {{5{pct[7]}}, pct};
    if (en) begin
      r = 13'sd1500 + px * 13'sd5;
    end else begin
      r = 13'sd1000 + px * 13'sd10;
    end
    if (r < 13'sd990) begin
      r = 13'sd990;
    end
    return r[10:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tsm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// tsm_cfg_regs
// APB-style configuration register file of the throttle step mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tsm_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [tsm_pkg::CfgDataW-1:0]  pwdata,
  output logic      [tsm_pkg::CfgDataW-1:0]  prdata,
  output logic                               pready,
  output tsm_pkg::cfg_t                      cfg_o
);
  import tsm_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brake_enable      <= RstBrakeEnable;
      cfg_q.short_press_ms    <= RstShortPressMs;
      cfg_q.long_press_ms     <= RstLongPressMs;
      cfg_q.overdrive_hold_ms <= RstOdHoldMs;
      cfg_q.presses_to_low    <= RstPressesLow;
      cfg_q.presses_to_med    <= RstPressesMed;
      cfg_q.low_percent       <= RstLowPercent;
      cfg_q.med_percent       <= RstMedPercent;
    end else if (wr_en) begin
      unique case (idx)
        REG_BRAKE_ENABLE:   cfg_q.brake_enable      <= pwdata[0];
        REG_SHORT_PRESS_MS: cfg_q.short_press_ms    <= pwdata[15:0];
        REG_LONG_PRESS_MS:  cfg_q.long_press_ms     <= pwdata[15:0];
        REG_OD_HOLD_MS:     cfg_q.overdrive_hold_ms <= pwdata[15:0];
        REG_PRESSES_LOW:    cfg_q.presses_to_low    <= pwdata[3:0];
        REG_PRESSES_MED:    cfg_q.presses_to_med    <= pwdata[3:0];
        REG_LOW_PERCENT:    cfg_q.low_percent       <= pwdata[6:0];
        REG_MED_PERCENT:    cfg_q.med_percent       <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_BRAKE_ENABLE:   prdata = {31'd0, cfg_q.brake_enable};
      REG_SHORT_PRESS_MS: prdata = {16'd0, cfg_q.short_press_ms};
      REG_LONG_PRESS_MS:  prdata = {16'd0, cfg_q.long_press_ms};
      REG_OD_HOLD_MS:     prdata = {16'd0, cfg_q.overdrive_hold_ms};
      REG_PRESSES_LOW:    prdata = {28'd0, cfg_q.presses_to_low};
      REG_PRESSES_MED:    prdata = {28'd0, cfg_q.presses_to_med};
      REG_LOW_PERCENT:    prdata = {25'd0, cfg_q.low_percent};
      REG_MED_PERCENT:    prdata = {25'd0, cfg_q.med_percent};
      default:            prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/tsm_step.sv =====
// ----------------------------------------------------------------------------
// tsm_step
// Next-state and result logic for one poll tick: release count, brake
// handling, overdrive expiry window or standard press handling.
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_step (
  input  wire tsm_pkg::cfg_t      cfg_i,
  input  wire tsm_pkg::st_t       st_i,
  input  wire tsm_pkg::in_item_t  item_i,
  output tsm_pkg::st_t            st_o,
  output tsm_pkg::out_item_t      res_o
);
  import tsm_pkg::*;

  st_t               s;
  logic              strobe;
  logic              handled;
  logic [31:0]       now;
  logic              pressed;
  logic              released;
  logic signed [7:0] pct;

  assign now      = item_i.now_ms;
  assign pressed  = item_i.button_press_edge;
  assign released = item_i.button_release_edge;

  always_comb begin
    s       = st_i;
    strobe  = 1'b0;
    handled = 1'b0;

    if (released && s.release_count != 4'd15) begin
      s.release_count = s.release_count + 4'd1;
    end

    // brake sensor
    if (cfg_i.brake_enable) begin
      if (item_i.brake_release_edge) begin
        s.short_dl = DlNever;
        s.long_dl  = DlNever;
        if (s.mode_now == MODE_OVER) begin
          s.expiry_dl     = now + {16'd0, cfg_i.overdrive_hold_ms};
          s.expiry_active = 1'b1;
          s.release_count = 4'd0;
        end
        s.mode_before = s.mode_now;
        s.mode_now    = MODE_BRAKE;
        if (s.mode_written != s.mode_now) begin
          s.mode_written = s.mode_now;
          strobe         = 1'b1;
        end
      end
      if (item_i.brake_press_edge) begin
        s.mode_now    = s.mode_before;
        s.mode_before = MODE_NONE;
        if (s.mode_written != s.mode_now) begin
          s.mode_written = s.mode_now;
          strobe         = 1'b1;
        end
      end
      if (s.mode_now == MODE_BRAKE) begin
        if (s.mode_written != s.mode_now) begin
          s.mode_written = s.mode_now;
          strobe         = 1'b1;
        end
        handled = 1'b1;
      end
    end

    if (!handled) begin
      if (s.expiry_active) begin
        // expiry window: no output write this tick
        if (now > s.expiry_dl || s.release_count >= cfg_i.presses_to_med) begin
          if (s.release_count == 4'd0) begin
            s.mode_now = s.mode_before;
          end else if (s.release_count == cfg_i.presses_to_low) begin
            s.mode_now = MODE_LOW;
          end else if (s.release_count == cfg_i.presses_to_med) begin
            s.mode_now = MODE_MED;
          end else begin
            s.mode_now = MODE_OFF;
          end
          s.mode_before   = released ? s.mode_now : MODE_NONE;
          s.expiry_dl     = DlNever;
          s.expiry_active = 1'b0;
          s.release_count = 4'd0;
        end
      end else begin
        if (pressed) begin
          s.short_dl = now + {16'd0, cfg_i.short_press_ms};
          s.long_dl  = now + {16'd0, cfg_i.long_press_ms};
        end
        if (released) begin
          if (s.mode_before == MODE_NONE) begin
            s.mode_now = MODE_OFF;
          end
          if (s.mode_now == MODE_OVER) begin
            s.expiry_dl     = now + {16'd0, cfg_i.overdrive_hold_ms};
            s.expiry_active = 1'b1;
            s.release_count = 4'd0;
          end else begin
            s.mode_before = MODE_NONE;
          end
          s.short_dl = DlNever;
          s.long_dl  = DlNever;
        end
        if (s.mode_before == MODE_NONE && now > s.short_dl) begin
          s.mode_before = s.mode_now;
          s.mode_now    = next_mode(s.mode_now);
          if (s.mode_now == MODE_OVER) begin
            s.mode_now = MODE_MED;
          end
        end
        if (s.mode_now != MODE_OVER && now > s.long_dl) begin
          s.mode_now = MODE_OVER;
        end
        if (s.mode_written != s.mode_now) begin
          s.mode_written = s.mode_now;
          strobe         = 1'b1;
        end
      end
    end
  end

  assign pct  = pct_of(s.mode_now, cfg_i);
  assign st_o = s;

  always_comb begin
    res_o.pulse_us         = pulse_of(cfg_i.brake_enable, pct);
    res_o.mode_code        = s.mode_now;
    res_o.throttle_percent = pct;
    res_o.write_strobe     = strobe;
  end

endmodule

`default_nettype wire

// ===== rtl/core/tsm_pipe.sv =====
// ----------------------------------------------------------------------------
// tsm_pipe
// Input register, controller state and result register around the tick logic.
// ----------------------------------------------------------------------------
`default_nettype none

module tsm_pipe (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tsm_pkg::cfg_t      cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire tsm_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output tsm_pkg::out_item_t      out_data_o
);
  import tsm_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  st_t       st_q;
  st_t       st_d;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res_d;
  logic      out_free;
  logic      advance;
  logic      accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  tsm_step u_step (
    .cfg_i  (cfg_i),
    .st_i   (st_q),
    .item_i (in_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= StRst;
    end else begin
      if (accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_adv_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q && out_q.mode_code == st_q.mode_now)
    else $error("result register not loaded with the new mode");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q && out_valid_q && !out_stall_i |=> !out_valid_q)
    else $error("taken item repeated");

  a_expiry_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.expiry_active |-> st_q.expiry_dl == DlNever)
    else $error("expiry deadline armed outside the window");

  a_written_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(st_q.mode_written) |-> $past(advance) && out_q.write_strobe)
    else $error("written mode changed without a strobe");

endmodule

`default_nettype wire

// ===== rtl/core/throttle_step_mode_controller.sv =====
// ----------------------------------------------------------------------------
// throttle_step_mode_controller
// Button driven throttle mode controller: off/low/med steps, overdrive on a
// long hold, expiry window, brake mode and servo pulse mapping.
// ----------------------------------------------------------------------------
// Each poll tick item gives exactly one result item. One item is taken every
// clock cycle unless a result held by out_stall_i blocks input. An accepted
// item is held in the input register, then its result in the result register,
// and the whole tick, including the state update, resolves combinationally
// between those two registers. A result waiting under out_stall_i stalls input
// only once the input register is also full. Configuration registers sit at
// byte addresses 4*i and may be written only while no item is in flight.
`default_nettype none

module throttle_step_mode_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [tsm_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [tsm_pkg::CfgDataW-1:0]  pwdata,
  output logic      [tsm_pkg::CfgDataW-1:0]  prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire tsm_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output tsm_pkg::out_item_t                 out_data_o
);
  import tsm_pkg::*;

  cfg_t cfg;

  tsm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tsm_pipe u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb_throttle_step_mode_controller.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_throttle_step_mode_controller
// Self-checking bench for the throttle step mode controller. Poll ticks are
// sent as directed rows, then as random button and brake gestures over a set
// of register settings. Each tick result is checked against an in-bench model
// of the mode logic and the servo pulse mapping, or against the typed result
// of a directed row. Both channels idle at random outside the quiet phase.

module tb_throttle_step_mode_controller;
  import tsm_pkg::*;

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [CfgDataW-1:0] pwdata      = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_item_t           out_data_o;

  throttle_step_mode_controller DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Controller model state, mirrors the block after reset
  cfg_t        cfg_sh      = '{RstBrakeEnable, RstShortPressMs, RstLongPressMs, RstOdHoldMs,
                               RstPressesLow, RstPressesMed, RstLowPercent, RstMedPercent};
  mode_e       ctl_mode    = MODE_OFF;
  mode_e       ctl_prev    = MODE_NONE;
  mode_e       ctl_shown   = MODE_NONE;
  logic [31:0] dl_short    = '1;
  logic [31:0] dl_long     = '1;
  logic [31:0] dl_expiry   = '1;
  logic        win_open    = 1'b0;
  logic [3:0]  rel_count   = '0;
  logic        strobe_now  = 1'b0;

  out_item_t   servo_q[$];
  int unsigned err_cnt     = 0;
  int unsigned items_sent  = 0;
  logic [31:0] t_ms        = '0;
  bit          quiet       = 1'b0;

  function automatic void mark_written();
    if (ctl_shown != ctl_mode) begin
      ctl_shown  = ctl_mode;
      strobe_now = 1'b1;
    end
  endfunction

  function automatic void open_window(logic [31:0] now);
    dl_expiry = now + 32'(cfg_sh.overdrive_hold_ms);
    win_open  = 1'b1;
    rel_count = '0;
  endfunction

  // One poll tick: updates the model state and returns the servo result
  function automatic out_item_t servo_tick(in_item_t it);
    out_item_t   r;
    logic [31:0] now;
    bit          braking;
    int          pct;
    int          pulse;
    now        = it.now_ms;
    strobe_now = 1'b0;
    braking    = 1'b0;
    if (it.button_release_edge && rel_count != 4'd15) rel_count = rel_count + 4'd1;

    if (cfg_sh.brake_enable) begin
      if (it.brake_release_edge) begin
        dl_short = '1;
        dl_long  = '1;
        if (ctl_mode == MODE_OVER) open_window(now);
        ctl_prev = ctl_mode;
        ctl_mode = MODE_BRAKE;
        mark_written();
      end
      if (it.brake_press_edge) begin
        ctl_mode = ctl_prev;
        ctl_prev = MODE_NONE;
        mark_written();
      end
      if (ctl_mode == MODE_BRAKE) begin
        mark_written();
        braking = 1'b1;
      end
    end

    if (!braking) begin
      if (win_open) begin
        // expiry window: no output write on this path
        if (now > dl_expiry || rel_count >= cfg_sh.presses_to_med) begin
          if (rel_count == 4'd0) ctl_mode = ctl_prev;
          else if (rel_count == cfg_sh.presses_to_low) ctl_mode = MODE_LOW;
          else if (rel_count == cfg_sh.presses_to_med) ctl_mode = MODE_MED;
          else ctl_mode = MODE_OFF;
          ctl_prev  = it.button_release_edge ? ctl_mode : MODE_NONE;
          dl_expiry = '1;
          win_open  = 1'b0;
          rel_count = '0;
        end
      end else begin
        if (it.button_press_edge) begin
          dl_short = now + 32'(cfg_sh.short_press_ms);
          dl_long  = now + 32'(cfg_sh.long_press_ms);
        end
        if (it.button_release_edge) begin
          if (ctl_prev == MODE_NONE) ctl_mode = MODE_OFF;
          if (ctl_mode == MODE_OVER) open_window(now);
          else ctl_prev = MODE_NONE;
          dl_short = '1;
          dl_long  = '1;
        end
        if (ctl_prev == MODE_NONE && now > dl_short) begin
          ctl_prev = ctl_mode;
          case (ctl_mode)
            MODE_NONE: ctl_mode = MODE_OFF;
            MODE_OFF:  ctl_mode = MODE_LOW;
            MODE_LOW:  ctl_mode = MODE_MED;
            MODE_MED:  ctl_mode = MODE_MED;   // a short hold never reaches overdrive
            default:   ctl_mode = MODE_NONE;
          endcase
        end
        if (ctl_mode != MODE_OVER && now > dl_long) ctl_mode = MODE_OVER;
        mark_written();
      end
    end

    case (ctl_mode)
      MODE_BRAKE: pct = -100;
      MODE_OFF:   pct = 0;
      MODE_LOW:   pct = (cfg_sh.low_percent > 7'd100) ? 100 : int'(cfg_sh.low_percent);
      MODE_MED:   pct = (cfg_sh.med_percent > 7'd100) ? 100 : int'(cfg_sh.med_percent);
      MODE_OVER:  pct = 100;
      default:    pct = -1;
    endcase
    pulse = cfg_sh.brake_enable ? 1000 + 5 * (pct + 100) : 1000 + 10 * pct;
    if (pulse < 990) pulse = 990;
    if (pulse > 2000) pulse = 2000;
    r.pulse_us         = pulse[10:0];
    r.mode_code        = ctl_mode;
    r.throttle_percent = pct[7:0];
    r.write_strobe     = strobe_now;
    return r;
  endfunction

  task automatic log_fail(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // Result side: random stall, compare in order
  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 32);
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (servo_q.size() == 0) begin
        log_fail($sformatf("unexpected item pulse=%0d mode=%0d pct=%0d strobe=%0b",
                           out_data_o.pulse_us, out_data_o.mode_code,
                           out_data_o.throttle_percent, out_data_o.write_strobe));
      end else begin
        want = servo_q.pop_front();
        if (out_data_o.pulse_us !== want.pulse_us || out_data_o.mode_code !== want.mode_code ||
            out_data_o.throttle_percent !== want.throttle_percent ||
            out_data_o.write_strobe !== want.write_strobe) begin
          log_fail($sformatf("mismatch exp pulse=%0d mode=%0d pct=%0d strobe=%0b, got %0d %0d %0d %0b",
                             want.pulse_us, want.mode_code, want.throttle_percent,
                             want.write_strobe, out_data_o.pulse_us, out_data_o.mode_code,
                             out_data_o.throttle_percent, out_data_o.write_strobe));
        end
      end
    end
  end

  // Send one tick; a typed result overrides the model's answer
  task automatic send_tick(in_item_t it, bit typed, out_item_t want);
    out_item_t model_out;
    while (!quiet && $urandom_range(99) < 32) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    model_out = servo_tick(it);
    servo_q.push_back(typed ? want : model_out);
    items_sent++;
  endtask

  task automatic tick(bit press, bit rel, bit brk_rel, bit brk_press, int unsigned adv);
    in_item_t it;
    t_ms = t_ms + adv;
    it.now_ms              = t_ms;
    it.button_press_edge   = press;
    it.button_release_edge = rel;
    it.brake_release_edge  = brk_rel;
    it.brake_press_edge    = brk_press;
    send_tick(it, 1'b0, '0);
  endtask

  // Plain ticks until strictly more than span ms have passed
  task automatic hold_past(int unsigned span);
    int unsigned done;
    int unsigned adv;
    done = 0;
    while (done <= span) begin
      adv = $urandom_range(1, span / 3 + 1);
      tick(1'b0, 1'b0, 1'b0, 1'b0, adv);
      done += adv;
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (servo_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Register write then readback
  task automatic cfg_write(reg_idx_e idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== val)
      log_fail($sformatf("reg %s readback exp %0h got %0h", idx.name(), val, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_BRAKE_ENABLE:   cfg_sh.brake_enable      = val[0];
      REG_SHORT_PRESS_MS: cfg_sh.short_press_ms    = val[15:0];
      REG_LONG_PRESS_MS:  cfg_sh.long_press_ms     = val[15:0];
      REG_OD_HOLD_MS:     cfg_sh.overdrive_hold_ms = val[15:0];
      REG_PRESSES_LOW:    cfg_sh.presses_to_low    = val[3:0];
      REG_PRESSES_MED:    cfg_sh.presses_to_med    = val[3:0];
      REG_LOW_PERCENT:    cfg_sh.low_percent       = val[6:0];
      REG_MED_PERCENT:    cfg_sh.med_percent       = val[6:0];
      default: ;
    endcase
  endtask

  task automatic apply_cfg(cfg_t c);
    drain();
    cfg_write(REG_BRAKE_ENABLE,   32'(c.brake_enable));
    cfg_write(REG_SHORT_PRESS_MS, 32'(c.short_press_ms));
    cfg_write(REG_LONG_PRESS_MS,  32'(c.long_press_ms));
    cfg_write(REG_OD_HOLD_MS,     32'(c.overdrive_hold_ms));
    cfg_write(REG_PRESSES_LOW,    32'(c.presses_to_low));
    cfg_write(REG_PRESSES_MED,    32'(c.presses_to_med));
    cfg_write(REG_LOW_PERCENT,    32'(c.low_percent));
    cfg_write(REG_MED_PERCENT,    32'(c.med_percent));
  endtask

  // One random user action
  task automatic run_gesture();
    int unsigned sp;
    int unsigned lp;
    int unsigned od;
    int unsigned n;
    int unsigned gap;
    int unsigned adv;
    int unsigned pick;
    sp   = 32'(cfg_sh.short_press_ms);
    lp   = 32'(cfg_sh.long_press_ms);
    od   = 32'(cfg_sh.overdrive_hold_ms);
    pick = $urandom_range(99);
    if (pick < 15) begin
      // quick tap
      tick(1'b1, 1'b0, 1'b0, 1'b0, $urandom_range(1, 5));
      if ($urandom_range(1)) tick(1'b0, 1'b0, 1'b0, 1'b0, $urandom_range(0, sp / 2));
      tick(1'b0, 1'b1, 1'b0, 1'b0, $urandom_range(0, sp / 2));
    end else if (pick < 35) begin
      tick(1'b1, 1'b0, 1'b0, 1'b0, $urandom_range(1, 5));
      hold_past(sp);
      tick(1'b0, 1'b1, 1'b0, 1'b0, $urandom_range(0, 3));
    end else if (pick < 60) begin
      // long hold, then release taps inside the expiry window
      tick(1'b1, 1'b0, 1'b0, 1'b0, $urandom_range(1, 5));
      hold_past(lp);
      tick(1'b0, 1'b1, 1'b0, 1'b0, $urandom_range(0, 3));
      n   = $urandom_range(0, 32'(cfg_sh.presses_to_med) + 2);
      gap = od / (2 * n + 2);
      repeat (n) begin
        tick(1'b1, 1'b0, 1'b0, 1'b0, $urandom_range(0, gap));
        tick(1'b0, 1'b1, 1'b0, 1'b0, $urandom_range(0, gap));
      end
      if ($urandom_range(1)) hold_past(od);
      else tick(1'b0, 1'b0, 1'b0, 1'b0, $urandom_range(0, 3));
    end else if (pick < 72) begin
      tick(1'b0, 1'b0, 1'b1, 1'b0, $urandom_range(0, 20));
      repeat ($urandom_range(0, 3))
        tick(1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, 1'b0,
             $urandom_range(0, lp));
      tick(1'b0, 1'b0, 1'b0, 1'b1, $urandom_range(0, 20));
    end else if (pick < 88) begin
      // noise: any edges, occasional jump anywhere in the time range
      repeat ($urandom_range(1, 6)) begin
        adv = ($urandom_range(99) < 10) ? $urandom : $urandom_range(0, lp + sp);
        tick($urandom_range(3) == 0, $urandom_range(3) == 0,
             $urandom_range(3) == 0, $urandom_range(3) == 0, adv);
      end
    end else begin
      repeat ($urandom_range(1, 4)) tick(1'b0, 1'b0, 1'b0, 1'b0, $urandom_range(0, 3));
    end
  endtask

  // Directed rows at reset settings: step to low, overdrive, expiry to med,
  // brake in and out, release to off, time wrap, all edges at once.
  typedef struct packed {
    in_item_t  stim;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam int DirRows = 21;
  localparam dir_row_t DirTab [DirRows] = '{
    '{'{32'd0,    1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{11'd1500, MODE_OFF,   8'sd0,    1'b1}},
    '{'{32'd10,   1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{11'd1500, MODE_OFF,   8'sd0,    1'b0}},
    '{'{32'd20,   1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, '{11'd1500, MODE_OFF,   8'sd0,    1'b0}},
    '{'{32'd521,  1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{11'd1650, MODE_LOW,   8'sd30,   1'b1}},
    '{'{32'd1021, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{11'd2000, MODE_OVER,  8'sd100,  1'b1}},
    '{'{32'd1030, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, '{11'd2000, MODE_OVER,  8'sd100,  1'b0}},
    '{'{32'd1100, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, '{11'd2000, MODE_OVER,  8'sd100,  1'b0}},
    '{'{32'd1110, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, '{11'd2000, MODE_OVER,  8'sd100,  1'b0}},
    '{'{32'd1120, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, '{11'd2000, MODE_OVER,  8'sd100,  1'b0}},
    '{'{32'd1130, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, '{11'd2000, MODE_OVER,  8'sd100,  1'b0}},
    '{'{32'd1140, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, '{11'd2000, MODE_OVER,  8'sd100,  1'b0}},
    '{'{32'd1150, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, '{11'd1800, MODE_MED,   8'sd60,   1'b0}},
    '{'{32'd1200, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b1, '{11'd1800, MODE_MED,   8'sd60,   1'b1}},
    '{'{32'd1300, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b1, '{11'd1000, MODE_BRAKE, -8'sd100, 1'b1}},
    '{'{32'd1400, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1, '{11'd1000, MODE_BRAKE, -8'sd100, 1'b0}},
    '{'{32'd1500, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b1, '{11'd1800, MODE_MED,   8'sd60,   1'b1}},
    '{'{32'd1510, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1, '{11'd1500, MODE_OFF,   8'sd0,    1'b1}},
    '{'{32'hFFFF_FF00, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{32'd0,    1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{32'd5,    1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0}
  };

  initial begin : stimulus
    cfg_t        c;
    int unsigned start;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DirRows; i++) send_tick(DirTab[i].stim, DirTab[i].typed, DirTab[i].want);
    t_ms = 32'd100;

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        // brake disabled while still in brake mode, zero counts, percents over 100
        0: c = '{1'b0, 16'd1, 16'd1, 16'd1, 4'd0, 4'd0, 7'd127, 7'd101};
        1: c = '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15, 4'd15, 7'd100, 7'd100};
        2: c = '{1'b1, 16'd20, 16'd60, 16'd200, 4'd3, 4'd3, 7'd0, 7'd0};
        3: c = '{1'b0, 16'd30, 16'd90, 16'd150, 4'd2, 4'd5, 7'd45, 7'd99};
        default: begin
          c.brake_enable      = 1'($urandom_range(1));
          c.short_press_ms    = 16'($urandom_range(0, 80));
          c.long_press_ms     = 16'($urandom_range(0, 200));
          c.overdrive_hold_ms = 16'($urandom_range(0, 400));
          c.presses_to_low    = 4'($urandom_range(0, 15));
          c.presses_to_med    = 4'($urandom_range(0, 15));
          c.low_percent       = 7'($urandom_range(0, 127));
          c.med_percent       = 7'($urandom_range(0, 127));
        end
      endcase
      apply_cfg(c);
      quiet = (ph == 2);
      start = items_sent;
      while (items_sent - start < 155) run_gesture();
    end
    quiet = 1'b0;

    drain();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && servo_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
